// ----- hdl/scp_file_record_parser_assert.svh -----
// Assertion macros shared by the checker of the record parser
`ifndef SCP_FILE_RECORD_PARSER_ASSERT_SVH
`define SCP_FILE_RECORD_PARSER_ASSERT_SVH

// Clocked property, ignored while reset is held
`define SCP_FRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked property, also checked during reset
`define SCP_FRP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hdl/scp_frp_pkg.sv -----
package scp_frp_pkg;

    // Field widths
    localparam int BYTE_W           = 8;
    localparam int CFG_W            = 9;
    localparam int MODE_W           = 32;
    localparam int SIZE_W           = 64;
    localparam int NAME_CAP_MAX_DEF = 256;

    // Capacity register value after reset
    localparam logic [CFG_W-1:0] CAP_RESET = 9'd256;

    // Characters of the record line
    localparam logic [BYTE_W-1:0] CH_C   = 8'h43;
    localparam logic [BYTE_W-1:0] CH_0   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_7   = 8'h37;
    localparam logic [BYTE_W-1:0] CH_9   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SP  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        PH_LETTER,
        PH_MODE,
        PH_SIZE,
        PH_NAME,
        PH_DONE,
        PH_FAIL
    } t_phase;

    // Status flags of one result item
    typedef struct packed {
        logic name_valid;
        logic verdict_valid;
        logic record_ok;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ----- hdl/scp_frp_core.sv -----
module scp_frp_core
    import scp_frp_pkg::*;
#(
    parameter int NAME_CAP_MAX = NAME_CAP_MAX_DEF,
    parameter int NW           = $clog2(NAME_CAP_MAX + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    input  logic [CFG_W-1:0]  i_cap,
    output t_flags            o_flags,
    output logic [BYTE_W-1:0] o_byte,
    output logic [MODE_W-1:0] o_mode,
    output logic [SIZE_W-1:0] o_size,
    output logic [NW-1:0]     o_len
);

    localparam int CW = (NW > CFG_W) ? NW : CFG_W;

    t_phase              r_phase, n_phase;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic                r_seen, n_seen;
    logic [NW-1:0]       r_count, n_count;
    logic                echo;
    logic                ok;
    logic                is_oct;
    logic                is_dec;
    logic [CW-1:0]       cap_ext;
    logic [CW-1:0]       cap_eff;
    logic [CW-1:0]       max_ext;

    assign is_oct = (i_byte >= CH_0) && (i_byte <= CH_7);
    assign is_dec = (i_byte >= CH_0) && (i_byte <= CH_9);

    // Next phase and accumulators for the byte at hand
    always_comb begin
        n_phase = r_phase;
        n_mode  = r_mode;
        n_size  = r_size;
        n_seen  = r_seen;
        n_count = r_count;
        echo    = 1'b0;
        unique case (r_phase)
            PH_LETTER: begin
                n_phase = (i_byte == CH_C) ? PH_MODE : PH_FAIL;
                n_seen  = 1'b0;
            end
            PH_MODE: begin
                priority if (is_oct) begin
                    n_mode = {r_mode[MODE_W-4:0], 3'b000} + {29'd0, i_byte[2:0]};
                    n_seen = 1'b1;
                end else if (i_byte == CH_SP && r_seen) begin
                    n_phase = PH_SIZE;
                    n_seen  = 1'b0;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_SIZE: begin
                priority if (is_dec) begin
                    n_size = {r_size[SIZE_W-4:0], 3'b000} + {r_size[SIZE_W-2:0], 1'b0}
                           + {60'd0, i_byte[3:0]};
                    n_seen = 1'b1;
                end else if (i_byte == CH_SP && r_seen) begin
                    n_phase = PH_NAME;
                    n_seen  = 1'b0;
                end else begin
                    n_phase = PH_FAIL;
                end
            end
            PH_NAME: begin
                if (i_byte == CH_NL || i_byte == CH_NUL) begin
                    n_phase = PH_DONE;
                end else begin
                    echo = 1'b1;
                    if (r_count < NW'(NAME_CAP_MAX)) begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Clamp the capacity and judge the line
    assign cap_ext = CW'(i_cap);
    assign max_ext = CW'(NAME_CAP_MAX);
    assign cap_eff = (cap_ext > max_ext) ? max_ext : cap_ext;
    assign ok      = i_last && (n_phase == PH_NAME || n_phase == PH_DONE)
                   && (n_count != '0) && (CW'(n_count) < cap_eff);

    assign o_flags.name_valid    = echo;
    assign o_flags.verdict_valid = i_last;
    assign o_flags.record_ok     = ok;
    assign o_byte = echo ? i_byte : '0;
    assign o_mode = ok ? n_mode : '0;
    assign o_size = ok ? n_size : '0;
    assign o_len  = ok ? n_count : '0;

    // Advance the parse state; clear it on reset and after the last byte of a line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_phase <= PH_LETTER;
            r_mode  <= '0;
            r_size  <= '0;
            r_seen  <= 1'b0;
            r_count <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_size  <= n_size;
            r_seen  <= n_seen;
            r_count <= n_count;
        end
    end

endmodule

// ----- hdl/scp_frp_obuf.sv -----
module scp_frp_obuf
    import scp_frp_pkg::*;
#(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic [W-1:0] i_data,
    output logic         o_can_load,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    // Room when empty or when the held item leaves this cycle
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- hdl/scp_file_record_parser.sv -----
// Record line parser: one byte item in, one result item out.
// The input register and then the result register lie between an accepted byte and its
// result on the master side. Throughput: 1 item per cycle while m_tready holds; the
// two registers form a two-stage pipeline whose only loop is the parse state update.
// Reset (synchronous, active low) empties both stages, returns the parser to
// expect the record letter and sets the name capacity to 256.
module scp_file_record_parser
    import scp_frp_pkg::*;
#(
    parameter int NAME_CAP_MAX = NAME_CAP_MAX_DEF,
    parameter int NW           = $clog2(NAME_CAP_MAX + 1),
    parameter int DW           = ((BYTE_W + 1 + MODE_W + SIZE_W + NW + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: name capacity
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // byte stream in
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // line_byte
    input  logic              s_tlast,   // line_end
    // result stream out
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DW-1:0]     m_tdata,   // name_byte, record_ok, file_mode, file_size,
                                         // name_length, zero fill
    output logic              m_tuser,   // name_byte_valid
    output logic              m_tlast    // verdict_valid
);

    localparam int RW  = FLAGS_W + BYTE_W + MODE_W + SIZE_W + NW;
    localparam int PAD = DW - (BYTE_W + 1 + MODE_W + SIZE_W + NW);

    logic [CFG_W-1:0]  r_cap;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              out_can_load;
    logic              step;
    t_flags            flags;
    t_flags            out_flags;
    logic [BYTE_W-1:0] res_byte;
    logic [MODE_W-1:0] res_mode;
    logic [SIZE_W-1:0] res_size;
    logic [NW-1:0]     res_len;
    logic [RW-1:0]     res_vec;
    logic [RW-1:0]     out_vec;
    logic [BYTE_W-1:0] out_byte;
    logic [MODE_W-1:0] out_mode;
    logic [SIZE_W-1:0] out_size;
    logic [NW-1:0]     out_len;

    // Capacity register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    // Input register
    assign step     = r_in_valid && out_can_load;
    assign s_tready = !r_in_valid || out_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
            r_in_last <= s_tlast;
        end
    end

    scp_frp_core #(
        .NAME_CAP_MAX (NAME_CAP_MAX),
        .NW           (NW)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_cap   (r_cap),
        .o_flags (flags),
        .o_byte  (res_byte),
        .o_mode  (res_mode),
        .o_size  (res_size),
        .o_len   (res_len)
    );

    assign res_vec = {flags, res_byte, res_mode, res_size, res_len};

    scp_frp_obuf #(
        .W (RW)
    ) u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_data     (res_vec),
        .o_can_load (out_can_load),
        .o_valid    (m_tvalid),
        .i_ready    (m_tready),
        .o_data     (out_vec)
    );

    // Unpack the result item onto the stream
    assign {out_flags, out_byte, out_mode, out_size, out_len} = out_vec;
    assign m_tdata = {{PAD{1'b0}}, out_len, out_size, out_mode, out_flags.record_ok, out_byte};
    assign m_tuser = out_flags.name_valid;
    assign m_tlast = out_flags.verdict_valid;

endmodule

// ----- hdl/scp_frp_checker.sv -----
`include "scp_file_record_parser_assert.svh"

module scp_frp_checker
    import scp_frp_pkg::*;
#(
    parameter int NAME_CAP_MAX = NAME_CAP_MAX_DEF,
    parameter int NW           = $clog2(NAME_CAP_MAX + 1),
    parameter int DW           = ((BYTE_W + 1 + MODE_W + SIZE_W + NW + 7) / 8) * 8
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [DW-1:0] m_tdata,
    input logic          m_tuser,
    input logic          m_tlast
);

    localparam int OK_BIT  = BYTE_W;
    localparam int LEN_LSB = BYTE_W + 1 + MODE_W + SIZE_W;

    // Hold a stalled result item
    `SCP_FRP_ASSERT(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result item changed while stalled")

    // A passing verdict appears only on the last item of a line
    `SCP_FRP_ASSERT(a_ok_on_verdict, m_tvalid && m_tdata[OK_BIT] |-> m_tlast, "record_ok without verdict")

    // A passing record always carries a nonempty name
    `SCP_FRP_ASSERT(a_ok_has_name, m_tvalid && m_tdata[OK_BIT] |-> m_tdata[LEN_LSB +: NW] != '0, "record_ok with empty name")

    // Drop name bytes that are not echoed
    `SCP_FRP_ASSERT(a_byte_zero, m_tvalid && !m_tuser |-> m_tdata[BYTE_W-1:0] == '0, "name byte set without valid")

endmodule

bind scp_file_record_parser scp_frp_checker #(
    .NAME_CAP_MAX (NAME_CAP_MAX)
) u_scp_frp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
